// ----- sv/sbpc_pkg.sv -----
// Package for the swept box platform collision block: widths, codes, handshake
// structs and the coordinate saturation function. Depends on nothing.
package sbpc_pkg;

  localparam int COORD_BITS     = 24;
  localparam int TIME_FRAC_BITS = 16;
  localparam int NUM_W          = COORD_BITS + 2;                    // slab numerator
  localparam int DEN_W          = COORD_BITS + TIME_FRAC_BITS;       // ray length d
  localparam int DVD_W          = NUM_W - 1 + 16 + TIME_FRAC_BITS;   // |num| << 32
  localparam int TIME_W         = DVD_W + 3;                         // signed slab time
  localparam int MUL_A_W        = DEN_W + 1;
  localparam int MUL_B_W        = TIME_FRAC_BITS + 2;
  localparam int MUL_P_W        = MUL_A_W + MUL_B_W;

  localparam logic signed [TIME_W-1:0] TIME_SAT = TIME_W'(64'd1 << 50);
  localparam logic signed [TIME_W-1:0] ONE_T    = TIME_W'(64'd1 << TIME_FRAC_BITS);
  localparam logic [15:0] ELAPSED_RESET = 16'd1092;

  // Input mode codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_MORE  = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  // Contact sides
  localparam logic [2:0] SIDE_NONE   = 3'd0;
  localparam logic [2:0] SIDE_TOP    = 3'd1;
  localparam logic [2:0] SIDE_BOTTOM = 3'd2;
  localparam logic [2:0] SIDE_LEFT   = 3'd3;
  localparam logic [2:0] SIDE_RIGHT  = 3'd4;

  // Register indexes
  localparam logic REG_ELAPSED = 1'b0;
  localparam logic REG_IGNORE  = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TIME_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd8388607;
    lo = -34'sd8388608;
    if (v > hi) return COORD_BITS'(hi);
    else if (v < lo) return COORD_BITS'(lo);
    else return v[COORD_BITS-1:0];
  endfunction

endpackage

// ----- sv/sbpc_div.sv -----
// Radix-2 restoring divider giving floor(num * 2^32 / den), one quotient bit a cycle.
// Depends on sbpc_pkg.
module sbpc_div (
  input  logic             clk,
  input  logic             rst,
  input  sbpc_pkg::div_req_t req,
  output sbpc_pkg::div_rsp_t rsp
);
  import sbpc_pkg::*;

  logic [DVD_W-1:0]   dvd;      // dividend shifting out, quotient shifting in
  logic [DEN_W-1:0]   dvs;
  logic [DEN_W:0]     rem;
  logic [5:0]         cnt;
  logic               busy;
  logic               done;
  logic               neg;
  logic [DEN_W:0]     trial;
  logic               qbit;
  logic [NUM_W-1:0]   num_abs;
  logic [DEN_W-1:0]   den_abs;
  logic [TIME_W-1:0]  qext;

  // Magnitudes of the operands, trial remainder and quotient bit
  always_comb begin
    num_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    den_abs = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
    trial   = {rem[DEN_W-1:0], dvd[DVD_W-1]};
    qbit    = (trial >= {1'b0, dvs});
  end

  // Iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= {num_abs[NUM_W-2:0], 32'd0};
        dvs  <= den_abs;
        rem  <= '0;
        cnt  <= '0;
        neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
        busy <= 1'b1;
      end else if (busy) begin
        rem <= qbit ? (trial - {1'b0, dvs}) : trial;
        dvd <= {dvd[DVD_W-2:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign fix-up toward minus infinity
  always_comb begin
    qext     = {3'b000, dvd};
    rsp.done = done;
    if (!neg) rsp.quot = qext;
    else if (rem != '0) rsp.quot = ~qext;
    else rsp.quot = -qext;
  end

endmodule

// ----- sv/swept_box_platform_collision_top.sv -----
// Top level of the swept box platform collision block: stream ports, APB registers,
// sequencer, shared multiplier. Depends on sbpc_pkg and sbpc_div.
//
// One transaction in at a time. A frame start is taken in the idle state; a frame end
// also passes through the output state. A platform/hurtbox pair runs through the
// sequencer as two multiplies for the ray, four slab quotients through the single
// 57-step divider, a sort step, a compare step and three more multiplies for the
// contact point and the velocity. A pair that is dropped early returns sooner. A
// finished result sits in the output register and the block takes the next
// transaction while it waits to be taken.
module swept_box_platform_collision_top (
  input  logic          clk,
  input  logic          rst,
  // mode[1:0]
  input  logic [1:0]    s_tuser,
  // rect_left, rect_top, rect_width, rect_height, rect_thin,
  // box_left, box_top, box_width, box_height, 3 zero bits
  input  logic [191:0]  s_tdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  // kind
  output logic [0:0]    m_tuser,
  // side, contact_time, point_x, point_y, new_vel_x, new_vel_y,
  // hit_top, hit_bottom, hit_left, hit_right, 1 zero bit
  output logic [119:0]  m_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import sbpc_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_MULX      = 11'b00000000010,
    ST_MULY      = 11'b00000000100,
    ST_DIV_ISSUE = 11'b00000001000,
    ST_DIV_WAIT  = 11'b00000010000,
    ST_SORT      = 11'b00000100000,
    ST_DECIDE    = 11'b00001000000,
    ST_PX        = 11'b00010000000,
    ST_PY        = 11'b00100000000,
    ST_RES       = 11'b01000000000,
    ST_OUT       = 11'b10000000000
  } state_t;

  state_t state;

  // Registers
  logic [15:0] elapsed_time;
  logic        ignore_thin;

  // Entity state
  logic signed [COORD_BITS-1:0] ray_vel_x, ray_vel_y, resolved_vel_x, resolved_vel_y;
  logic [3:0]  side_flags;
  logic        platform_closed;

  // Latched pair
  logic signed [23:0] rl, rt, bl, bt;
  logic [22:0]        rw, rh, bw, bh;
  logic               thin;

  // Working values
  logic signed [DEN_W-1:0]  dx, dy;
  logic signed [TIME_W-1:0] tm [4];
  logic signed [TIME_W-1:0] nx, ny, fx, fy;
  logic [1:0]               idx;
  logic [15:0]              hn;
  logic signed [MUL_P_W-1:0] prod;

  // Result register contents
  logic        r_kind;
  logic [2:0]  r_side;
  logic [15:0] r_time;
  logic signed [23:0] r_px, r_py;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sbpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Input unpack
  logic [1:0]         in_mode;
  logic signed [23:0] in_rl, in_rt;
  logic               in_thin;
  logic               in_drop;
  assign in_mode = s_tuser;
  assign in_rl   = s_tdata[23:0];
  assign in_rt   = s_tdata[47:24];
  assign in_thin = s_tdata[94];

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;

  // Register read
  always_comb begin
    if (paddr[2] == REG_IGNORE) prdata = {31'd0, ignore_thin};
    else prdata = {16'd0, elapsed_time};
  end

  // Slab numerator and ray length for the current quotient
  logic signed [NUM_W-1:0] num_sel;
  logic signed [DEN_W-1:0] den_sel;
  always_comb begin
    case (idx)
      2'd0:    num_sel = NUM_W'(rl) - NUM_W'(bl) - NUM_W'({1'b0, bw});
      2'd1:    num_sel = NUM_W'(rt) - NUM_W'(bt) - NUM_W'({1'b0, bh});
      2'd2:    num_sel = NUM_W'(rl) + NUM_W'({1'b0, rw}) - NUM_W'(bl);
      default: num_sel = NUM_W'(rt) + NUM_W'({1'b0, rh}) - NUM_W'(bt);
    endcase
    den_sel = idx[0] ? dy : dx;
    div_req.start = (state == ST_DIV_ISSUE) && (den_sel != '0);
    div_req.num   = num_sel;
    div_req.den   = den_sel;
  end

  // Resolve axis and magnitude
  logic               res_y;
  logic signed [23:0] res_v;
  logic signed [24:0] res_vv;
  logic [24:0]        res_mag;
  always_comb begin
    res_y   = (r_side == SIDE_TOP) || (r_side == SIDE_BOTTOM);
    res_v   = res_y ? resolved_vel_y : resolved_vel_x;
    res_vv  = {res_v[23], res_v};
    res_mag = res_vv[24] ? 25'(-res_vv) : 25'(res_vv);
  end

  // Shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MULX: begin
        mul_a = MUL_A_W'(ray_vel_x);
        mul_b = MUL_B_W'({1'b0, elapsed_time});
      end
      ST_MULY: begin
        mul_a = MUL_A_W'(ray_vel_y);
        mul_b = MUL_B_W'({1'b0, elapsed_time});
      end
      ST_PX: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'({1'b0, hn});
      end
      ST_PY: begin
        mul_a = MUL_A_W'(dy);
        mul_b = MUL_B_W'({1'b0, hn});
      end
      ST_RES: begin
        mul_a = MUL_A_W'({1'b0, res_mag});
        mul_b = MUL_B_W'(17'h10000 - {1'b0, hn});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Contact point from the registered product: floor((2*origin*2^31 + t*d) / 2^32)
  logic signed [NUM_W-1:0] pt_org;
  logic signed [63:0]      pt_sum;
  logic signed [23:0]      pt_sat;
  always_comb begin
    if (state == ST_PY) pt_org = NUM_W'($signed({bl, 1'b0})) + NUM_W'({1'b0, bw});
    else pt_org = NUM_W'($signed({bt, 1'b0})) + NUM_W'({1'b0, bh});
    pt_sum = (64'(pt_org) <<< 31) + 64'(prod);
    pt_sat = sat_coord({{2{pt_sum[63]}}, pt_sum[63:32]});
  end

  // Velocity resolution from the registered product
  logic [24:0]        delta;
  logic signed [26:0] res_sum;
  logic signed [23:0] res_new;
  always_comb begin
    delta = prod[40:16];
    if ((r_side == SIDE_TOP) || (r_side == SIDE_LEFT))
      res_sum = 27'(res_v) - 27'({2'b00, delta});
    else
      res_sum = 27'(res_v) + 27'({2'b00, delta});
    res_new = sat_coord(34'(res_sum));
  end

  // Hit decision on the sorted slab times
  logic                     sep;
  logic signed [TIME_W-1:0] hit_near, hit_far;
  always_comb begin
    sep      = (nx > fy) || (ny > fx);
    hit_near = (nx > ny) ? nx : ny;
    hit_far  = (fx < fy) ? fx : fy;
  end

  assign in_drop = ((in_mode == MODE_MORE) && platform_closed) || (ignore_thin && in_thin) ||
                   ((ray_vel_x == '0) && (ray_vel_y == '0));

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      elapsed_time    <= ELAPSED_RESET;
      ignore_thin     <= 1'b0;
      ray_vel_x       <= '0;
      ray_vel_y       <= '0;
      resolved_vel_x  <= '0;
      resolved_vel_y  <= '0;
      side_flags      <= '0;
      platform_closed <= 1'b0;
      m_tvalid        <= 1'b0;
      idx             <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ELAPSED) elapsed_time <= pwdata[15:0];
        else ignore_thin <= pwdata[0];
      end
      // Output valid: set when a result is handed over, cleared when taken
      if ((state == ST_OUT) && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            rl   <= in_rl;
            rt   <= in_rt;
            rw   <= s_tdata[70:48];
            rh   <= s_tdata[93:71];
            thin <= in_thin;
            bl   <= s_tdata[118:95];
            bt   <= s_tdata[142:119];
            bw   <= s_tdata[165:143];
            bh   <= s_tdata[188:166];
            idx  <= '0;
            case (in_mode)
              MODE_START: begin
                ray_vel_x       <= in_rl;
                resolved_vel_x  <= in_rl;
                ray_vel_y       <= in_rt;
                resolved_vel_y  <= in_rt;
                side_flags      <= '0;
                platform_closed <= 1'b1;
              end
              MODE_END: begin
                r_kind <= 1'b1;
                r_side <= SIDE_NONE;
                r_time <= '0;
                r_px   <= '0;
                r_py   <= '0;
                state  <= ST_OUT;
              end
              default: begin
                if (in_mode == MODE_OPEN) platform_closed <= 1'b0;
                if (!in_drop) state <= ST_MULX;
              end
            endcase
          end
        end
        ST_MULX: begin
          dx    <= mul_p[DEN_W-1:0];
          state <= ST_MULY;
        end
        ST_MULY: begin
          dy    <= mul_p[DEN_W-1:0];
          state <= ST_DIV_ISSUE;
        end
        ST_DIV_ISSUE: begin
          if (den_sel != '0) begin
            state <= ST_DIV_WAIT;
          end else if (num_sel == '0) begin
            state <= ST_IDLE;
          end else begin
            tm[idx] <= num_sel[NUM_W-1] ? -TIME_SAT : TIME_SAT;
            idx     <= idx + 2'd1;
            state   <= (idx == 2'd3) ? ST_SORT : ST_DIV_ISSUE;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            tm[idx] <= div_rsp.quot;
            idx     <= idx + 2'd1;
            state   <= (idx == 2'd3) ? ST_SORT : ST_DIV_ISSUE;
          end
        end
        ST_SORT: begin
          nx    <= (tm[0] > tm[2]) ? tm[2] : tm[0];
          fx    <= (tm[0] > tm[2]) ? tm[0] : tm[2];
          ny    <= (tm[1] > tm[3]) ? tm[3] : tm[1];
          fy    <= (tm[1] > tm[3]) ? tm[1] : tm[3];
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          hn     <= hit_near[15:0];
          r_kind <= 1'b0;
          r_time <= hit_near[15:0];
          if (sep || (hit_far < 0)) begin
            state <= ST_IDLE;
          end else if ((hit_near < 0) || (hit_near >= ONE_T)) begin
            platform_closed <= 1'b1;
            state           <= ST_IDLE;
          end else if (nx > ny) begin
            if (thin) begin
              state <= ST_IDLE;
            end else begin
              r_side          <= dx[DEN_W-1] ? SIDE_RIGHT : SIDE_LEFT;
              side_flags      <= side_flags | (dx[DEN_W-1] ? 4'b1000 : 4'b0100);
              platform_closed <= 1'b1;
              state           <= ST_PX;
            end
          end else if (nx < ny) begin
            if (dy[DEN_W-1] && thin) begin
              state <= ST_IDLE;
            end else begin
              r_side          <= dy[DEN_W-1] ? SIDE_BOTTOM : SIDE_TOP;
              side_flags      <= side_flags | (dy[DEN_W-1] ? 4'b0010 : 4'b0001);
              platform_closed <= 1'b1;
              state           <= ST_PX;
            end
          end else begin
            r_side          <= SIDE_NONE;
            platform_closed <= 1'b1;
            state           <= ST_PX;
          end
        end
        ST_PX: begin
          prod  <= mul_p;
          state <= ST_PY;
        end
        ST_PY: begin
          r_px  <= pt_sat;
          prod  <= mul_p;
          state <= ST_RES;
        end
        ST_RES: begin
          r_py  <= pt_sat;
          prod  <= mul_p;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            logic signed [23:0] vx_out, vy_out;
            vx_out = resolved_vel_x;
            vy_out = resolved_vel_y;
            if (!r_kind && (r_side != SIDE_NONE)) begin
              if (res_y) begin
                resolved_vel_y <= res_new;
                vy_out = res_new;
              end else begin
                resolved_vel_x <= res_new;
                vx_out = res_new;
              end
            end
            m_tuser  <= r_kind;
            m_tdata  <= {1'b0, side_flags[3], side_flags[2], side_flags[1], side_flags[0],
                         vy_out, vx_out, r_py, r_px, r_time, r_side};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider answers only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> state == ST_DIV_WAIT)
    else $error("divider result outside wait state");

  // A divider start, made only from the issue step, is followed by the wait step
  assert property (@(posedge clk) disable iff (rst) div_req.start |=> state == ST_DIV_WAIT)
    else $error("divider started without wait");

  // A result leaving the sequencer shows up on the output
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("result lost at output register");

  // Side flags only gain bits while a pair is in work
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> ((side_flags & $past(side_flags)) == $past(side_flags)))
    else $error("side flag cleared mid pair");

endmodule

// ----- sim/sbpc_checker.sv -----
// Checker for the swept box platform collision block: watches the stream and APB
// channels, predicts each result and compares it. Depends on sbpc_pkg.
module sbpc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   s_tuser,
  input  logic [191:0] s_tdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [0:0]   m_tuser,
  input  logic [119:0] m_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending,
  output int           checked
);
  import sbpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit        kind;
    bit [2:0]  side;
    bit [15:0] ctime;
    bit [23:0] px;
    bit [23:0] py;
    bit [23:0] vx;
    bit [23:0] vy;
    bit [3:0]  flags;
  } contact_t;

  // Ring of expected results, oldest at rd_ptr
  localparam int QDEPTH = 64;
  contact_t ring [QDEPTH];
  int       wr_ptr = 0;
  int       rd_ptr = 0;
  int       fill = 0;

  // Predictor copy of configuration and frame state
  longint    elapsed;
  bit        skip_thin;
  longint    ray_vx, ray_vy, run_vx, run_vy;
  bit [3:0]  side_flags;
  bit        plat_closed;

  localparam longint TSAT = 64'sd1 << 50;
  localparam longint ONE  = 64'sd1 << TIME_FRAC_BITS;

  function automatic longint clamp24(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint div_floor(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  // Slab entry/exit time; 0 means 0/0, the hurtbox is skipped
  function automatic bit slab_time(input longint num, input longint d, output longint t);
    t = 0;
    if (d == 0) begin
      if (num == 0) return 0;
      t = (num > 0) ? TSAT : -TSAT;
      return 1;
    end
    t = div_floor(num * (64'sd1 << (16 + TIME_FRAC_BITS)), d);
    return 1;
  endfunction

  function automatic longint resolve_vel(input longint v, input int n, input longint t);
    longint mag;
    mag = (v < 0) ? -v : v;
    return clamp24(v + n * ((mag * (ONE - t)) >>> TIME_FRAC_BITS));
  endfunction

  // Works out the result of one accepted item; returns 1 if one is due
  function automatic bit predict_contact(input logic [1:0] mode, input logic [191:0] d,
                                         output contact_t e);
    longint rl, rt, rw, rh, bl, bt, bw, bh;
    longint dx, dy, nx, ny, fx, fy, tmp, t_near, t_far, px, py;
    bit thin;
    int normx, normy;
    bit [2:0] side;
    rl = longint'($signed(d[23:0]));
    rt = longint'($signed(d[47:24]));
    rw = longint'(d[70:48]);
    rh = longint'(d[93:71]);
    thin = d[94];
    bl = longint'($signed(d[118:95]));
    bt = longint'($signed(d[142:119]));
    bw = longint'(d[165:143]);
    bh = longint'(d[188:166]);
    normx = 0;
    normy = 0;
    side = SIDE_NONE;
    e = '{default: '0};
    if (mode == MODE_START) begin
      ray_vx = rl; run_vx = rl;
      ray_vy = rt; run_vy = rt;
      side_flags = '0;
      plat_closed = 1;
      return 0;
    end
    if (mode == MODE_END) begin
      e.kind = 1;
      e.vx = run_vx[23:0];
      e.vy = run_vy[23:0];
      e.flags = side_flags;
      return 1;
    end
    if (mode == MODE_OPEN) plat_closed = 0;
    else if (plat_closed) return 0;
    if (skip_thin && thin) return 0;
    if (ray_vx == 0 && ray_vy == 0) return 0;

    dx = ray_vx * elapsed;
    dy = ray_vy * elapsed;
    if (!slab_time(rl - bl - bw, dx, nx)) return 0;
    if (!slab_time(rt - bt - bh, dy, ny)) return 0;
    if (!slab_time(rl + rw - bl, dx, fx)) return 0;
    if (!slab_time(rt + rh - bt, dy, fy)) return 0;
    if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
    if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
    if (nx > fy || ny > fx) return 0;
    t_near = (nx > ny) ? nx : ny;
    t_far = (fx < fy) ? fx : fy;
    if (t_far < 0) return 0;
    if (t_near < 0 || t_near >= ONE) begin
      plat_closed = 1;
      return 0;
    end

    // Side from the later entry; thin platforms drop side and bottom hits
    if (nx > ny) begin
      if (thin) return 0;
      if (dx < 0) begin side = SIDE_RIGHT; normx = 1; end
      else begin side = SIDE_LEFT; normx = -1; end
    end else if (nx < ny) begin
      if (dy < 0) begin
        if (thin) return 0;
        side = SIDE_BOTTOM; normy = 1;
      end else begin
        side = SIDE_TOP; normy = -1;
      end
    end
    plat_closed = 1;
    if (side != SIDE_NONE) side_flags[side - 1] = 1'b1;

    px = div_floor((2 * bl + bw) * (64'sd1 << (15 + TIME_FRAC_BITS)) + t_near * dx,
                   64'sd1 << (16 + TIME_FRAC_BITS));
    py = div_floor((2 * bt + bh) * (64'sd1 << (15 + TIME_FRAC_BITS)) + t_near * dy,
                   64'sd1 << (16 + TIME_FRAC_BITS));
    run_vy = resolve_vel(run_vy, normy, t_near);
    run_vx = resolve_vel(run_vx, normx, t_near);

    e.kind = 0;
    e.side = side;
    e.ctime = t_near[15:0];
    px = clamp24(px);
    py = clamp24(py);
    e.px = px[23:0];
    e.py = py[23:0];
    e.vx = run_vx[23:0];
    e.vy = run_vy[23:0];
    e.flags = side_flags;
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp);
    fail_count++;
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    contact_t e;
    contact_t x;
    if (rst) begin
      elapsed = 1092;
      skip_thin = 0;
      ray_vx = 0; ray_vy = 0; run_vx = 0; run_vy = 0;
      side_flags = '0;
      plat_closed = 0;
      wr_ptr = 0;
      rd_ptr = 0;
      fill = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ELAPSED) elapsed = longint'(pwdata[15:0]);
        else skip_thin = pwdata[0];
      end
      // Result transaction
      if (m_tvalid && m_tready) begin
        checked++;
        if (fill == 0) begin
          $display("[%0t] result transaction with nothing expected", $time);
          fail_count++;
        end else begin
          x = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDEPTH;
          fill--;
          if (m_tuser[0] !== x.kind)       report_mismatch("kind", m_tuser[0], x.kind);
          if (m_tdata[2:0] !== x.side)     report_mismatch("side", m_tdata[2:0], x.side);
          if (m_tdata[18:3] !== x.ctime)   report_mismatch("contact_time", m_tdata[18:3], x.ctime);
          if (m_tdata[42:19] !== x.px)     report_mismatch("point_x", m_tdata[42:19], x.px);
          if (m_tdata[66:43] !== x.py)     report_mismatch("point_y", m_tdata[66:43], x.py);
          if (m_tdata[90:67] !== x.vx)     report_mismatch("new_vel_x", m_tdata[90:67], x.vx);
          if (m_tdata[114:91] !== x.vy)    report_mismatch("new_vel_y", m_tdata[114:91], x.vy);
          if (m_tdata[118:115] !== x.flags)
            report_mismatch("hit flags", m_tdata[118:115], x.flags);
        end
      end
      // Input transaction
      if (s_tvalid && s_tready) begin
        if (predict_contact(s_tuser, s_tdata, e)) begin
          if (fill == QDEPTH) begin
            $display("[%0t] expected results overflow", $time);
            fail_count++;
          end else begin
            ring[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % QDEPTH;
            fill++;
          end
        end
      end
    end
    pending = fill;
  end

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

endmodule

// ----- sim/tb_swept_box_platform_collision_top.sv -----
// Testbench top for swept_box_platform_collision_top: clock, reset, stimulus, APB
// writes and verdict. Depends on sbpc_pkg, the block and sbpc_checker.
module tb_swept_box_platform_collision_top;
  import sbpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic [1:0]   s_tuser = '0;
  logic [191:0] s_tdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [0:0]   m_tuser;
  logic [119:0] m_tdata;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  fail_count, pending, checked;
  int  sent = 0;
  int  cycles = 0;
  bit  calm = 0;

  localparam int LIMIT = 1500000;

  swept_box_platform_collision_top dut (.*);

  sbpc_checker chk (
    .clk, .rst, .s_tuser, .s_tdata, .s_tvalid, .s_tready, .m_tuser, .m_tdata,
    .m_tvalid, .m_tready, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .checked
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall before each result transaction
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 5);
      repeat (n) begin
        @(negedge clk);
        m_tready <= 0;
      end
      @(negedge clk);
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [23:0] rl, rt,
                           input logic [22:0] rw, rh, input logic thin,
                           input logic [23:0] bl, bt, input logic [22:0] bw, bh);
    int n;
    n = calm ? 0 : $urandom_range(0, 5);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 0;
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {3'b000, bh, bw, bt, bl, thin, rh, rw, rt, rl};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Stop sending, drain all results, then let a dropped pair finish
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic [23:0] soff(input logic [23:0] base, input int span);
    return base + 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  // One random frame: mostly well formed with geometry near the ray, some noise
  task automatic random_frame;
    logic [23:0] vx, vy, bl, bt, rl, rt;
    logic [22:0] bw, bh, rw, rh;
    int np, nb, pick;
    pick = $urandom_range(0, 9);
    vx = 24'($signed($urandom_range(400000)) - 200000);
    vy = 24'($signed($urandom_range(400000)) - 200000);
    if (pick == 0) vx = '0;
    else if (pick == 1) vy = '0;
    else if (pick == 2) begin vx = 24'($urandom); vy = 24'($urandom); end
    send_item(MODE_START, vx, vy, 23'($urandom), 23'($urandom), 1'($urandom_range(1)),
              24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom));
    np = $urandom_range(1, 4);
    for (int p = 0; p < np; p++) begin
      bl = 24'($signed($urandom_range(40000)) - 20000);
      bt = 24'($signed($urandom_range(40000)) - 20000);
      rl = soff(bl, 9000);
      rt = soff(bt, 9000);
      rw = 23'($urandom_range(256, 12000));
      rh = 23'($urandom_range(256, 12000));
      nb = $urandom_range(1, 3);
      for (int b = 0; b < nb; b++) begin
        bw = 23'($urandom_range(256, 8192));
        bh = 23'($urandom_range(256, 8192));
        if ($urandom_range(0, 9) == 0)
          send_item(2'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
                    23'($urandom), 1'($urandom_range(1)), 24'($urandom), 24'($urandom),
                    23'($urandom), 23'($urandom));
        else
          send_item(b == 0 ? MODE_OPEN : MODE_MORE, rl, rt, rw, rh, 1'($urandom_range(1)),
                    soff(bl, 1500), soff(bt, 1500), bw, bh);
      end
    end
    send_item(MODE_END, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
  endtask

  initial begin
    logic [15:0] et[6];
    logic        it[6];
    int          start;
    et = '{16'd1092, 16'hFFFF, 16'd0, 16'd1, 16'd32768, 16'($urandom)};
    it = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: further hurtbox straight after reset, then basic contacts
    calm = 1;
    send_item(MODE_MORE, 24'd5376, '0, 23'd5120, 23'd5120, 1'b0, '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_START, 24'd153600, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    // left side hit, then a further hurtbox on the closed platform
    send_item(MODE_OPEN, 24'd5376, -24'sd2560, 23'd5120, 23'd10240, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_MORE, 24'd5376, -24'sd2560, 23'd5120, 23'd10240, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    // side hit on a thin platform is skipped
    send_item(MODE_OPEN, 24'd5376, -24'sd2560, 23'd5120, 23'd10240, 1'b1,
              '0, '0, 23'd4096, 23'd4096);
    // leftward: right side hit
    send_item(MODE_START, -24'sd153600, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    send_item(MODE_OPEN, -24'sd6400, -24'sd2560, 23'd5120, 23'd10240, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_END, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    // downward onto a thin top, then upward into a thin bottom and a solid one
    send_item(MODE_START, '0, 24'd153600, '0, '0, 1'b0, '0, '0, '0, '0);
    send_item(MODE_OPEN, -24'sd2560, 24'd5376, 23'd10240, 23'd2560, 1'b1,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_START, '0, -24'sd153600, '0, '0, 1'b0, '0, '0, '0, '0);
    send_item(MODE_OPEN, -24'sd2560, -24'sd3840, 23'd10240, 23'd2560, 1'b1,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_OPEN, -24'sd2560, -24'sd3840, 23'd10240, 23'd2560, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    // diagonal with equal entry times, and a platform beyond the ray
    send_item(MODE_START, 24'd153600, 24'd153600, '0, '0, 1'b0, '0, '0, '0, '0);
    send_item(MODE_OPEN, 24'd5376, 24'd5376, 23'd10240, 23'd10240, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_OPEN, 24'd500000, 24'd500000, 23'd256, 23'd256, 1'b0,
              '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_END, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    // zero velocity, then extreme field values
    send_item(MODE_START, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    send_item(MODE_OPEN, '0, '0, 23'd2560, 23'd2560, 1'b0, '0, '0, 23'd4096, 23'd4096);
    send_item(MODE_START, 24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 1'b1,
              24'h800000, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
    send_item(MODE_OPEN, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 1'b0,
              24'h7FFFFF, 24'h800000, 23'h7FFFFF, 23'h7FFFFF);
    send_item(MODE_OPEN, 24'h7FFFFF, 24'h800000, '0, '0, 1'b0,
              24'h800000, 24'h7FFFFF, '0, '0);
    send_item(MODE_OPEN, '0, '0, 23'h7FFFFF, 23'h7FFFFF, 1'b0, '0, '0, '0, '0);
    send_item(MODE_END, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
    calm = 0;
    drain();

    // Random phases, one per register setting
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(REG_ELAPSED, {16'd0, et[ph]});
      apb_write(REG_IGNORE, {31'd0, it[ph]});
      start = sent;
      calm = (ph == 3);
      while (sent - start < 135) random_frame();
      drain();
    end

    $display("covered %0d input transactions and %0d result transactions", sent, checked);
    $display("across six register settings including both elapsed time extremes");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
